// ----- hdl/rwev_pkg.sv -----
// Shared constants, register indexes and helper functions for the rough-wall
// eddy viscosity pipeline. No dependencies.
package rwev_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CMU   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 2'd1;

    localparam logic [15:0] CMU_RESET   = 16'd35894;
    localparam logic [15:0] KAPPA_RESET = 16'd26870;

    // ln values in Q.28, log2 fraction in Q.32
    localparam int LN_FRAC  = 28;
    localparam int LOG_FRAC = 32;
    localparam int G_W      = 34;
    localparam logic [27:0]    LN2_Q28    = 28'd186065280;
    localparam logic [G_W-1:0] LN_MIN_Q28 = 34'd26842;

    // index of the top set bit of a 33-bit value
    function automatic logic [5:0] top_bit33(input logic [32:0] v);
        logic [5:0] e;
        e = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                e = 6'(i);
            end
        end
        return e;
    endfunction

    // cycles from the accepting edge to the edge that samples the result
    function automatic int pipe_latency(input int frac_bits);
        int sn;
        sn = (frac_bits + 33) / 2;
        return 100 + sn - frac_bits;
    endfunction

endpackage

// ----- hdl/rough_wall_eddy_viscosity_top.sv -----
// Rough-wall eddy viscosity, fully pipelined, one beat per cycle in and out.
// The pipeline holds the bit-per-stage square root, two 32-stage log2
// squaring chains and the bit-per-stage divider. busy stays low;
// throughput is one beat a cycle. Synchronous active-low reset clears the
// valid chain and loads the two config registers with their reset values.
// Depends on rwev_pkg.
module rough_wall_eddy_viscosity_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [rwev_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rwev_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]                     i_tke,
    input  logic [31:0]                     i_wall_dist,
    input  logic [31:0]                     i_rough_len,
    input  logic [31:0]                     i_visc,
    output logic                            o_valid,
    output logic signed [31:0]              o_eddy_visc,
    output logic                            o_saturated
);
    import rwev_pkg::*;

    localparam int SN    = (FRAC_BITS + 33) / 2;
    localparam int RADW  = 2 * SN;
    localparam int RW    = SN + 3;
    localparam int AW    = SN + 32 - FRAC_BITS;
    localparam int NW    = AW + LN_FRAC;
    localparam int DA    = 34 - SN;
    localparam int DLAST = 38 + NW;
    localparam int LAST  = DLAST + 1;
    localparam int DW    = NW + 1;

    localparam logic signed [DW-1:0] R_MAX = DW'(32'h7fff_ffff);
    localparam logic signed [DW-1:0] R_MIN = {{(DW-32){1'b1}}, 32'h8000_0000};

    logic [15:0] r_cmu, r_kap;
    logic        r_vld [0:LAST];

    // square root
    logic [RADW-1:0] r_sx [0:SN];
    logic [RW-1:0]   r_sr [0:SN];
    logic [SN-1:0]   r_sq [0:SN];
    logic [RADW-1:0] n_sx [1:SN];
    logic [RW-1:0]   n_sr [1:SN];
    logic [SN-1:0]   n_sq [1:SN];

    logic [31:0]       r_yd [0:SN+1];
    logic [31:0]       r_z0;
    logic [FRAC_BITS-1:0] r_nu [0:DLAST];

    logic [SN-1:0]    r_u;
    logic [AW-1:0]    r_a0;
    logic [AW-1:0]    r_ad [0:DA];
    logic [SN+15:0]   w_u_prod;
    logic [SN+31:0]   w_uy_prod;
    logic [AW+15:0]   w_ak_prod;

    // log2 lanes: 0 is y+z0, 1 is z0
    logic [32:0] r_v  [2];
    logic [32:0] r_vn [2];
    logic [5:0]  r_ve [2];
    logic [31:0] r_lm [2][0:32];
    logic [31:0] r_lf [2][0:32];
    logic [5:0]  r_le [2][0:32];
    logic [31:0] n_lm [2][1:32];
    logic [31:0] n_lf [2][1:32];
    logic [32:0] w_norm [2];

    logic [37:0]    r_d;
    logic [G_W-1:0] r_g;
    logic [61:0]    w_g_prod;

    // divider
    logic [NW-1:0]  r_dn [0:NW];
    logic [G_W-1:0] r_dr [0:NW];
    logic [G_W-1:0] r_dg [0:NW];
    logic [NW-1:0]  n_dn [1:NW];
    logic [G_W-1:0] n_dr [1:NW];

    logic signed [DW-1:0] w_diff;
    logic signed [31:0]   r_res;
    logic                 r_sat;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmu <= CMU_RESET;
            r_kap <= KAPPA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CMU:   r_cmu <= i_cfg_data;
                CFG_KAPPA: r_kap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LAST; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int j = 1; j <= LAST; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // square root, one result bit per stage
    always_comb begin
        logic [RW-1:0] sh;
        logic [RW-1:0] tr;
        logic          ge;
        for (int j = 1; j <= SN; j++) begin
            sh = {r_sr[j-1][RW-3:0], r_sx[j-1][RADW-1:RADW-2]};
            tr = RW'({r_sq[j-1], 2'b01});
            ge = (sh >= tr);
            n_sr[j] = ge ? (sh - tr) : sh;
            n_sq[j] = {r_sq[j-1][SN-2:0], ge};
            n_sx[j] = r_sx[j-1] << 2;
        end
    end

    assign w_u_prod  = (SN+16)'(r_sq[SN]) * (SN+16)'(r_cmu);
    assign w_uy_prod = (SN+32)'(r_u) * (SN+32)'(r_yd[SN+1]);
    assign w_ak_prod = (AW+16)'(r_a0) * (AW+16)'(r_kap);

    // log2 by repeated squaring
    always_comb begin
        logic [63:0] p;
        for (int l = 0; l < 2; l++) begin
            w_norm[l] = r_vn[l] << (6'd32 - r_ve[l]);
            for (int k = 1; k <= 32; k++) begin
                p = 64'(r_lm[l][k-1]) * 64'(r_lm[l][k-1]);
                if (p[63]) begin
                    n_lm[l][k] = p[63:32];
                end else begin
                    n_lm[l][k] = p[62:31];
                end
                n_lf[l][k] = {r_lf[l][k-1][30:0], p[63]};
            end
        end
    end

    assign w_g_prod = 62'(r_d[37:4]) * 62'(LN2_Q28);

    // restoring division, quotient shifts in behind the numerator
    always_comb begin
        logic [G_W:0] sh;
        logic         ge;
        for (int i = 1; i <= NW; i++) begin
            sh = {r_dr[i-1], r_dn[i-1][NW-1]};
            ge = (sh >= {1'b0, r_dg[i-1]});
            n_dr[i] = ge ? G_W'(sh - {1'b0, r_dg[i-1]}) : sh[G_W-1:0];
            n_dn[i] = {r_dn[i-1][NW-2:0], ge};
        end
    end

    assign w_diff = signed'({1'b0, r_dn[NW]}) - signed'(DW'(r_nu[DLAST]));

    always_ff @(posedge i_clk) begin
        r_sx[0] <= RADW'(i_tke) << FRAC_BITS;
        r_sr[0] <= '0;
        r_sq[0] <= '0;
        r_yd[0] <= i_wall_dist;
        r_z0    <= (i_rough_len == 32'd0) ? 32'd1 : i_rough_len;
        r_nu[0] <= i_visc[31 -: FRAC_BITS];
        for (int j = 1; j <= SN; j++) begin
            r_sx[j] <= n_sx[j];
            r_sr[j] <= n_sr[j];
            r_sq[j] <= n_sq[j];
        end
        for (int j = 1; j <= SN + 1; j++) begin
            r_yd[j] <= r_yd[j-1];
        end
        for (int j = 1; j <= DLAST; j++) begin
            r_nu[j] <= r_nu[j-1];
        end

        r_u     <= w_u_prod[SN+15:16];
        r_a0    <= w_uy_prod[SN+31:FRAC_BITS];
        r_ad[0] <= w_ak_prod[AW+15:16];
        for (int j = 1; j <= DA; j++) begin
            r_ad[j] <= r_ad[j-1];
        end

        r_v[0] <= {1'b0, r_yd[0]} + {1'b0, r_z0};
        r_v[1] <= {1'b0, r_z0};
        for (int l = 0; l < 2; l++) begin
            r_vn[l]    <= r_v[l];
            r_ve[l]    <= top_bit33(r_v[l]);
            r_lm[l][0] <= w_norm[l][32:1];
            r_lf[l][0] <= '0;
            r_le[l][0] <= r_ve[l];
            for (int k = 1; k <= 32; k++) begin
                r_lm[l][k] <= n_lm[l][k];
                r_lf[l][k] <= n_lf[l][k];
                r_le[l][k] <= r_le[l][k-1];
            end
        end

        if ({r_le[0][32], r_lf[0][32]} >= {r_le[1][32], r_lf[1][32]}) begin
            r_d <= {r_le[0][32], r_lf[0][32]} - {r_le[1][32], r_lf[1][32]};
        end else begin
            r_d <= '0;
        end
        r_g <= w_g_prod[61:28];

        r_dg[0] <= (r_g < LN_MIN_Q28) ? LN_MIN_Q28 : r_g;
        r_dn[0] <= {r_ad[DA], {LN_FRAC{1'b0}}};
        r_dr[0] <= '0;
        for (int i = 1; i <= NW; i++) begin
            r_dn[i] <= n_dn[i];
            r_dr[i] <= n_dr[i];
            r_dg[i] <= r_dg[i-1];
        end

        priority if (w_diff > R_MAX) begin
            r_res <= 32'sh7fff_ffff;
            r_sat <= 1'b1;
        end else if (w_diff < R_MIN) begin
            r_res <= 32'sh8000_0000;
            r_sat <= 1'b1;
        end else begin
            r_res <= w_diff[31:0];
            r_sat <= 1'b0;
        end
    end

    assign o_valid     = r_vld[LAST];
    assign o_eddy_visc = r_res;
    assign o_saturated = r_sat;

endmodule

// ----- hdl/rwev_checker.sv -----
// Port-level checks for rough_wall_eddy_viscosity_top, bound to the top level.
// Depends on rwev_pkg for the pipeline latency.
module rwev_checker #(
    parameter int FRAC_BITS = 24
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [31:0] o_eddy_visc,
    input logic               o_saturated
);
    import rwev_pkg::*;

    localparam int LAT = pipe_latency(FRAC_BITS);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted beat produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted beat");

    a_sat_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_eddy_visc == 32'sh7fff_ffff))
        else $error("saturated result not at positive limit");

endmodule

bind rough_wall_eddy_viscosity_top rwev_checker #(.FRAC_BITS(FRAC_BITS)) u_rwev_checker (.*);

// ----- test/rough_wall_eddy_viscosity_top_tb.sv -----
// Testbench for rough_wall_eddy_viscosity_top: drives random and corner wall faces,
// predicts each eddy viscosity beat in a scoreboard class and compares in order.
// Depends on rwev_pkg and the DUT.
module rough_wall_eddy_viscosity_top_tb;
    import rwev_pkg::*;

    localparam int FB = 24;
    localparam int LAT = 104;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic [31:0] i_tke, i_wall_dist, i_rough_len, i_visc;
    logic        o_valid;
    logic signed [31:0] o_eddy_visc;
    logic        o_saturated;

    int err_cnt = 0;
    int idle_cycles = 0;

    rough_wall_eddy_viscosity_top #(.FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_tke(i_tke), .i_wall_dist(i_wall_dist), .i_rough_len(i_rough_len),
        .i_visc(i_visc), .o_valid(o_valid), .o_eddy_visc(o_eddy_visc),
        .o_saturated(o_saturated)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h exp %h", what, got, exp);
        err_cnt++;
    endtask

    typedef struct {
        logic signed [31:0] visc;
        logic               sat;
    } eddy_t;

    class eddy_scoreboard;
        logic [15:0] cmu;
        logic [15:0] kappa;
        eddy_t pending[$];

        function new();
            cmu = CMU_RESET;
            kappa = KAPPA_RESET;
        endfunction

        function automatic logic [63:0] isqrt(input logic [63:0] x);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [63:0] log2q(input logic [63:0] v);
            int e;
            logic [63:0] m, f;
            e = 0;
            f = 0;
            while (e < 63 && (v >> (e + 1)) != 0) e++;
            m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
            for (int i = 0; i < 32; i++) begin
                m = (m * m) >> 31;
                f <<= 1;
                if (m >= (64'd1 << 32)) begin
                    f |= 1;
                    m >>= 1;
                end
            end
            return (64'(e) << 32) | f;
        endfunction

        function void note_face(input logic [31:0] k, y, z0, nu);
            logic [63:0] z, s, u, a, ly, lz, d, g, q, rm, t;
            longint r;
            eddy_t e;
            z = (z0 == 0) ? 64'd1 : 64'(z0);
            s = isqrt(64'(k) << FB);
            u = (64'(cmu) * s) >> 16;
            a = (((u * 64'(y)) >> FB) * 64'(kappa)) >> 16;
            ly = log2q(64'(y) + z);
            lz = log2q(z);
            d = (ly >= lz) ? ly - lz : 0;
            g = ((d >> 4) * 64'(LN2_Q28)) >> 28;
            if (g < 64'(LN_MIN_Q28)) g = 64'(LN_MIN_Q28);
            q = a / g;
            rm = a % g;
            t = (q << 28) + ((rm << 28) / g);
            r = longint'(t) - longint'(64'(nu) >> (32 - FB));
            e.sat = 1'b0;
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647;
                e.sat = 1'b1;
            end else if (r < -64'sd2147483648) begin
                r = -64'sd2147483648;
                e.sat = 1'b1;
            end
            e.visc = r[31:0];
            pending.push_back(e);
        endfunction

        task check_result(input logic [31:0] v, input logic sat);
            eddy_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", v, 0);
                return;
            end
            e = pending.pop_front();
            if (v !== e.visc) report("eddy_visc", v, e.visc);
            if (sat !== e.sat) report("saturated", 32'(sat), 32'(e.sat));
        endtask
    endclass

    eddy_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_eddy_visc, o_saturated);
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        if (idx == CFG_CMU) sb.cmu = val;
        else if (idx == CFG_KAPPA) sb.kappa = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // sender drops start only between bursts
    task automatic send_face(input logic [31:0] k, y, z0, nu, input bit last_in_burst);
        i_tke = k;
        i_wall_dist = y;
        i_rough_len = z0;
        i_visc = nu;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_face(k, y, z0, nu);
        @(negedge i_clk);
        if (last_in_burst) start = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LAT + 10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0100_0000);
            2: return 32'h0100_0000 >> $urandom_range(0, 24);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_run(input int n);
        int left, burst, gap;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++) begin
                send_face(rnd_word($urandom_range(0, 3)), rnd_word($urandom_range(0, 3)),
                          rnd_word($urandom_range(0, 3)), $urandom, i == burst - 1);
            end
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    logic [31:0] corner [6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0100_0000,
                                 32'h8000_0000, 32'h5555_5555};

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CMU;
        i_cfg_data = '0;
        i_tke = '0;
        i_wall_dist = '0;
        i_rough_len = 32'd1;
        i_visc = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < 18; i++) begin
            send_face(corner[i % 6], corner[(i / 3) % 6], corner[(i + 2) % 6],
                      corner[(i / 2) % 6], 1'b1);
        end
        send_face(32'h0100_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
        send_face(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        drain();

        random_run(200);
        drain();
        write_reg(CFG_CMU, 16'hFFFF);
        write_reg(CFG_KAPPA, 16'hFFFF);
        random_run(150);
        drain();
        write_reg(CFG_CMU, 16'h0000);
        write_reg(CFG_KAPPA, 16'h0000);
        random_run(100);
        drain();
        write_reg(2'd3, 16'h1234);
        write_reg(CFG_CMU, 16'($urandom));
        write_reg(CFG_KAPPA, 16'($urandom));
        random_run(150);
        drain();
        write_reg(CFG_CMU, CMU_RESET);
        write_reg(CFG_KAPPA, KAPPA_RESET);
        random_run(150);
        drain();

        if (err_cnt == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
